[rtl/lmpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lmpc_pkg;

    localparam int ADDR_BITS    = 27;
    localparam int BLOCK_WORDS  = 262144;
    localparam int INDEX_BITS   = 28;
    localparam int MB_SHIFT     = 18;
    localparam int RAND_BITS    = 20;
    localparam int SIZE_BITS    = 10;
    localparam int PASS_BITS    = 7;
    localparam int WORD_BITS    = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WORD_BITS-1:0] SEED_RESET = 32'd12467;
    localparam logic [SIZE_BITS-1:0] SIZE_RESET = 10'd8;
    localparam logic [PASS_BITS-1:0] PASS_RESET = 7'd126;

    localparam logic [CFG_IDX_BITS-1:0] REG_TEST_MODE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEED_VALUE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_MB    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PASS_COUNT = 2'd3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LW   = 3'd1,
        PH_LR   = 3'd2,
        PH_RW   = 3'd3,
        PH_RR   = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_DONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic                  test_mode;
        logic [WORD_BITS-1:0]  seed;
        logic [SIZE_BITS-1:0]  size_mb;
        logic [PASS_BITS-1:0]  pass_count;
    } cfg_t;

    typedef struct packed {
        logic                  issue;
        logic [WORD_BITS-1:0]  expected;
        logic [ADDR_BITS-1:0]  address;
    } rd_req_t;

    typedef struct packed {
        logic                  mismatch;
        logic [ADDR_BITS-1:0]  address;
        logic [WORD_BITS-1:0]  expected;
        logic [WORD_BITS-1:0]  good_run;
        logic                  all_good;
    } chk_status_t;

    // shift left, OR in 1 on bit 22, then XOR 1 on bit 21
    function automatic logic [WORD_BITS-1:0] lfsr_adv(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] s;
        s = {v[WORD_BITS-2:0], 1'b0};
        s[0] = s[22];
        s[0] = s[0] ^ s[21];
        return s;
    endfunction

endpackage

`default_nettype wire

[rtl/lmpc_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmpc_sequencer import lmpc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start_fire,
    input  wire logic                  step_fire,
    input  wire cfg_t                  cfg,
    output cmd_t                       cmd,
    output logic [ADDR_BITS-1:0]       word_address,
    output logic [WORD_BITS-1:0]       write_data,
    output rd_req_t                    rd_req
);

    phase_t                 phase_reg, phase_next, ph_eff;
    logic [WORD_BITS-1:0]   lfsr_reg, lfsr_next, lf_eff;
    logic [WORD_BITS-1:0]   saved_reg, saved_next, sv_eff;
    logic [INDEX_BITS-1:0]  index_reg, index_next, wi_eff;
    logic [PASS_BITS-1:0]   pass_reg, pass_next, pi_eff;
    logic [INDEX_BITS-1:0]  limit;
    logic [PASS_BITS-1:0]   passes;
    logic [RAND_BITS-1:0]   rand_word;

    assign limit  = INDEX_BITS'(cfg.size_mb) << MB_SHIFT;
    assign passes = (cfg.pass_count == '0) ? PASS_BITS'(1) : cfg.pass_count;

    // resolve phase boundaries before the slot is issued
    always_comb begin
        ph_eff = phase_reg;
        lf_eff = lfsr_reg;
        sv_eff = saved_reg;
        wi_eff = index_reg;
        pi_eff = pass_reg;
        if (ph_eff == PH_LW && wi_eff >= limit) begin
            ph_eff = PH_LR;
            wi_eff = '0;
            lf_eff = sv_eff;
        end
        if (ph_eff == PH_LR && wi_eff >= limit) begin
            ph_eff = PH_DONE;
        end
        if (ph_eff == PH_RW && wi_eff >= INDEX_BITS'(BLOCK_WORDS)) begin
            ph_eff = PH_RR;
            wi_eff = '0;
            lf_eff = sv_eff;
        end
        if (ph_eff == PH_RR && wi_eff >= INDEX_BITS'(BLOCK_WORDS)) begin
            lf_eff = lfsr_adv(lf_eff);
            pi_eff = pi_eff + PASS_BITS'(1);
            if (pi_eff >= passes) begin
                ph_eff = PH_DONE;
            end else begin
                ph_eff = PH_RW;
                wi_eff = '0;
                sv_eff = lf_eff;
            end
        end
    end

    assign rand_word = lf_eff[RAND_BITS-1:0];

    // next state
    always_comb begin
        phase_next = phase_reg;
        lfsr_next  = lfsr_reg;
        saved_next = saved_reg;
        index_next = index_reg;
        pass_next  = pass_reg;
        if (start_fire) begin
            phase_next = cfg.test_mode ? PH_RW : PH_LW;
            lfsr_next  = cfg.seed;
            saved_next = cfg.seed;
            index_next = '0;
            pass_next  = '0;
        end else if (step_fire) begin
            phase_next = ph_eff;
            saved_next = sv_eff;
            pass_next  = pi_eff;
            lfsr_next  = lf_eff;
            index_next = wi_eff;
            case (ph_eff)
                PH_LW, PH_LR, PH_RW, PH_RR: begin
                    lfsr_next  = lfsr_adv(lf_eff);
                    index_next = wi_eff + INDEX_BITS'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // slot outputs
    always_comb begin
        cmd          = CMD_NONE;
        word_address = '0;
        write_data   = '0;
        rd_req       = '0;
        case (ph_eff)
            PH_LW: begin
                cmd          = CMD_WRITE;
                word_address = wi_eff[ADDR_BITS-1:0];
                write_data   = lf_eff;
            end
            PH_LR: begin
                cmd             = CMD_READ;
                word_address    = wi_eff[ADDR_BITS-1:0];
                rd_req.issue    = 1'b1;
                rd_req.expected = lf_eff;
                rd_req.address  = wi_eff[ADDR_BITS-1:0];
            end
            PH_RW: begin
                cmd          = CMD_WRITE;
                word_address = ADDR_BITS'(rand_word);
                write_data   = WORD_BITS'(rand_word);
            end
            PH_RR: begin
                cmd             = CMD_READ;
                word_address    = ADDR_BITS'(rand_word);
                rd_req.issue    = 1'b1;
                rd_req.expected = WORD_BITS'(rand_word);
                rd_req.address  = ADDR_BITS'(rand_word);
            end
            PH_DONE: begin
                cmd = CMD_DONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            lfsr_reg  <= '0;
            saved_reg <= '0;
            index_reg <= '0;
            pass_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
            saved_reg <= saved_next;
            index_reg <= index_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lmpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lmpc_checker import lmpc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start_fire,
    input  wire logic                  step_fire,
    input  wire logic [WORD_BITS-1:0]  read_data,
    input  wire rd_req_t               rd_req,
    output chk_status_t                status
);

    logic                   pend_reg, pend_next;
    logic [WORD_BITS-1:0]   exp_reg, exp_next;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [WORD_BITS-1:0]   run_reg, run_next;
    logic                   good_reg, good_next;
    logic                   miss;

    assign miss = pend_reg && (read_data != exp_reg);

    always_comb begin
        status          = '0;
        status.mismatch = miss;
        status.all_good = good_reg && !miss;
        if (miss) begin
            status.address  = addr_reg;
            status.expected = exp_reg;
            status.good_run = run_reg;
        end
    end

    always_comb begin
        pend_next = pend_reg;
        exp_next  = exp_reg;
        addr_next = addr_reg;
        run_next  = run_reg;
        good_next = good_reg;
        if (start_fire) begin
            pend_next = 1'b0;
            exp_next  = '0;
            addr_next = '0;
            run_next  = '0;
            good_next = 1'b1;
        end else if (step_fire) begin
            if (miss) begin
                run_next  = '0;
                good_next = 1'b0;
            end else if (pend_reg && run_reg != '1) begin
                run_next = run_reg + WORD_BITS'(1);
            end
            pend_next = rd_req.issue;
            if (rd_req.issue) begin
                exp_next  = rd_req.expected;
                addr_next = rd_req.address;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            exp_reg  <= '0;
            addr_reg <= '0;
            run_reg  <= '0;
            good_reg <= 1'b1;
        end else begin
            pend_reg <= pend_next;
            exp_reg  <= exp_next;
            addr_reg <= addr_next;
            run_reg  <= run_next;
            good_reg <= good_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lfsr_memory_pattern_checker_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// LFSR memory self-test engine. A start word (s_action = 0) loads the seed and
// mode and clears the error counters; each step word (s_action = 1) returns one
// memory command on the m_ side (none, write, read or finished) and checks
// s_read_data against the word expected for the read issued by the previous
// step. Linear mode writes LFSR words over size_megabytes * 2^18 word addresses
// and reads them back; random mode runs pass_count write/read passes of
// 262144 words at address = data = lfsr & 0xfffff. A mismatch reports the
// failing address, the expected word and the count of good reads before it.
// One word is taken per clock while s_ready is high: the work for a word is a single
// combinational pass from the state registers into the result register, and s_ready
// stays high while that register is empty or being drained, so the result for a word
// is offered in the cycle after it is taken. Write configuration only while idle.

module lfsr_memory_pattern_checker_top import lmpc_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration write port
    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [WORD_BITS-1:0]     cfg_wdata,
    // input words
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_action,
    input  wire logic [WORD_BITS-1:0]     s_read_data,
    // result words
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [1:0]                    m_command,
    output logic [ADDR_BITS-1:0]          m_word_address,
    output logic [WORD_BITS-1:0]          m_write_data,
    output logic                          m_mismatch,
    output logic [ADDR_BITS-1:0]          m_error_address,
    output logic [WORD_BITS-1:0]          m_expected_word,
    output logic [WORD_BITS-1:0]          m_good_run,
    output logic                          m_passed
);

    cfg_t          cfg_reg;
    logic          accept;
    logic          start_fire;
    logic          step_fire;
    cmd_t          cmd;
    logic [ADDR_BITS-1:0] word_address;
    logic [WORD_BITS-1:0] write_data;
    rd_req_t       rd_req;
    chk_status_t   status;
    logic          m_valid_reg;

    // advance whenever the result register is free or being emptied
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign start_fire = accept && (s_action == ACT_START);
    assign step_fire  = accept && (s_action == ACT_STEP);
    assign m_valid    = m_valid_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.test_mode  <= 1'b0;
            cfg_reg.seed       <= SEED_RESET;
            cfg_reg.size_mb    <= SIZE_RESET;
            cfg_reg.pass_count <= PASS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TEST_MODE:  cfg_reg.test_mode  <= cfg_wdata[0];
                REG_SEED_VALUE: cfg_reg.seed       <= cfg_wdata;
                REG_SIZE_MB:    cfg_reg.size_mb    <= cfg_wdata[SIZE_BITS-1:0];
                REG_PASS_COUNT: cfg_reg.pass_count <= cfg_wdata[PASS_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    lmpc_sequencer u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_fire   (start_fire),
        .step_fire    (step_fire),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .word_address (word_address),
        .write_data   (write_data),
        .rd_req       (rd_req)
    );

    lmpc_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_fire (start_fire),
        .step_fire  (step_fire),
        .read_data  (s_read_data),
        .rd_req     (rd_req),
        .status     (status)
    );

    // result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (start_fire) begin
                // a start word always answers with an empty command
                m_command       <= CMD_NONE;
                m_word_address  <= '0;
                m_write_data    <= '0;
                m_mismatch      <= 1'b0;
                m_error_address <= '0;
                m_expected_word <= '0;
                m_good_run      <= '0;
                m_passed        <= 1'b0;
            end else begin
                m_command       <= cmd;
                m_word_address  <= word_address;
                m_write_data    <= write_data;
                m_mismatch      <= status.mismatch;
                m_error_address <= status.address;
                m_expected_word <= status.expected;
                m_good_run      <= status.good_run;
                m_passed        <= (cmd == CMD_DONE) && status.all_good;
            end
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lmpc_pkg::*;

    localparam int CYCLE_LIMIT = 20_000;  // hang guard, far above the slowest legal run
    localparam int HOLD_CYCLES = 48;      // one long result-side hold-off
    localparam int PRINT_CAP   = 40;      // keep the log short on a badly broken block
    localparam int SHORT_TESTS = 15;      // short random tests after the directed cases
    localparam int QUIET_TESTS = 2;       // trailing tests run without any idling

    // One result word as the engine should emit it.
    typedef struct packed {
        cmd_t                 command;
        logic [ADDR_BITS-1:0] addr;
        logic [WORD_BITS-1:0] wdata;
        logic                 mismatch;
        logic [ADDR_BITS-1:0] err_addr;
        logic [WORD_BITS-1:0] want_word;
        logic [WORD_BITS-1:0] run;
        logic                 passed;
    } slot_cmd_t;

    // Tracks the self-test engine word by word and holds the command words still due.
    class slot_predictor;
        logic                  mode;
        logic [WORD_BITS-1:0]  seed;
        logic [SIZE_BITS-1:0]  size_mb;
        logic [PASS_BITS-1:0]  pass_cfg;

        logic [WORD_BITS-1:0]  lfsr;
        logic [WORD_BITS-1:0]  lfsr_mark;
        phase_t                ph;
        logic [INDEX_BITS-1:0] idx;
        logic [PASS_BITS-1:0]  pass_no;
        logic [WORD_BITS-1:0]  good_cnt;
        logic                  all_ok;
        logic [WORD_BITS-1:0]  pend_word;
        logic [ADDR_BITS-1:0]  pend_addr;
        logic                  pend;

        slot_cmd_t due_cmds[$];
        int errors, checked, flagged, finished;

        function new();
            mode      = 1'b0;
            seed      = SEED_RESET;
            size_mb   = SIZE_RESET;
            pass_cfg  = PASS_RESET;
            lfsr      = '0;
            lfsr_mark = '0;
            ph        = PH_IDLE;
            idx       = '0;
            pass_no   = '0;
            good_cnt  = '0;
            all_ok    = 1'b1;
            pend_word = '0;
            pend_addr = '0;
            pend      = 1'b0;
            errors    = 0;
            checked   = 0;
            flagged   = 0;
            finished  = 0;
        endfunction

        function void load_cfg(cfg_t c);
            mode     = c.test_mode;
            seed     = c.seed;
            size_mb  = c.size_mb;
            pass_cfg = c.pass_count;
        endfunction

        // shift left; feedback bit is set by bit 22 and toggled by bit 21
        function logic [WORD_BITS-1:0] lfsr_step(logic [WORD_BITS-1:0] v);
            logic [WORD_BITS-1:0] n;
            n = v << 1;
            if (n[22]) n[0] = 1'b1;
            if (n[21]) n[0] = ~n[0];
            return n;
        endfunction

        function void accept_word(logic act, logic [WORD_BITS-1:0] rd);
            slot_cmd_t             r;
            logic [INDEX_BITS-1:0] limit;
            logic [PASS_BITS-1:0]  npass;
            logic [RAND_BITS-1:0]  v;
            r     = '0;
            limit = {size_mb, {MB_SHIFT{1'b0}}};
            npass = (pass_cfg == '0) ? 7'd1 : pass_cfg;
            if (act == ACT_START) begin
                lfsr      = seed;
                lfsr_mark = seed;
                idx       = '0;
                pass_no   = '0;
                good_cnt  = '0;
                all_ok    = 1'b1;
                pend      = 1'b0;
                pend_word = '0;
                pend_addr = '0;
                ph        = mode ? PH_RW : PH_LW;
            end else begin
                // judge the word returned for the previous read first
                if (pend) begin
                    if (rd != pend_word) begin
                        r.mismatch  = 1'b1;
                        r.err_addr  = pend_addr;
                        r.want_word = pend_word;
                        r.run       = good_cnt;
                        good_cnt    = '0;
                        all_ok      = 1'b0;
                    end else if (good_cnt != '1) begin
                        good_cnt = good_cnt + 1'b1;
                    end
                    pend = 1'b0;
                end

                if (ph == PH_LW && idx >= limit) begin
                    ph   = PH_LR;
                    idx  = '0;
                    lfsr = lfsr_mark;
                end
                if (ph == PH_LR && idx >= limit) ph = PH_DONE;
                if (ph == PH_RW && idx >= BLOCK_WORDS) begin
                    ph   = PH_RR;
                    idx  = '0;
                    lfsr = lfsr_mark;
                end
                if (ph == PH_RR && idx >= BLOCK_WORDS) begin
                    lfsr    = lfsr_step(lfsr);
                    pass_no = pass_no + 1'b1;
                    if (pass_no >= npass) begin
                        ph = PH_DONE;
                    end else begin
                        ph        = PH_RW;
                        idx       = '0;
                        lfsr_mark = lfsr;
                    end
                end

                case (ph)
                    PH_LW, PH_LR: begin
                        r.addr = idx[ADDR_BITS-1:0];
                        if (ph == PH_LW) begin
                            r.command = CMD_WRITE;
                            r.wdata   = lfsr;
                        end else begin
                            r.command = CMD_READ;
                            pend_word = lfsr;
                            pend_addr = r.addr;
                            pend      = 1'b1;
                        end
                        lfsr = lfsr_step(lfsr);
                        idx  = idx + 1'b1;
                    end
                    PH_RW, PH_RR: begin
                        v      = lfsr[RAND_BITS-1:0];
                        r.addr = ADDR_BITS'(v);
                        if (ph == PH_RW) begin
                            r.command = CMD_WRITE;
                            r.wdata   = WORD_BITS'(v);
                        end else begin
                            r.command = CMD_READ;
                            pend_word = WORD_BITS'(v);
                            pend_addr = r.addr;
                            pend      = 1'b1;
                        end
                        lfsr = lfsr_step(lfsr);
                        idx  = idx + 1'b1;
                    end
                    PH_DONE: begin
                        r.command = CMD_DONE;
                        r.passed  = all_ok;
                    end
                    default: ;
                endcase
            end
            if (r.mismatch) flagged++;
            if (r.command == CMD_DONE) finished++;
            due_cmds.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] result %0d: %s", $time, checked, msg);
        endtask

        task compare(string field, logic [WORD_BITS-1:0] got, logic [WORD_BITS-1:0] want);
            if (got !== want)
                report($sformatf("%s is %h, should be %h", field, got, want));
        endtask

        task check_command(slot_cmd_t got);
            slot_cmd_t want;
            if (due_cmds.size() == 0) begin
                report("result word with nothing outstanding");
                return;
            end
            want = due_cmds.pop_front();
            checked++;
            compare("command",       32'(got.command), 32'(want.command));
            compare("word_address",  32'(got.addr),     32'(want.addr));
            compare("write_data",    got.wdata,         want.wdata);
            compare("mismatch",      32'(got.mismatch), 32'(want.mismatch));
            compare("error_address", 32'(got.err_addr), 32'(want.err_addr));
            compare("expected_word", got.want_word,     want.want_word);
            compare("good_run",      got.run,           want.run);
            compare("passed",        32'(got.passed),   32'(want.passed));
        endtask
    endclass

    // ---------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                    aclk;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index   = REG_TEST_MODE;
    logic [WORD_BITS-1:0]    cfg_wdata   = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic                    s_action    = ACT_STEP;
    logic [WORD_BITS-1:0]    s_read_data = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [1:0]              m_command;
    logic [ADDR_BITS-1:0]    m_word_address;
    logic [WORD_BITS-1:0]    m_write_data;
    logic                    m_mismatch;
    logic [ADDR_BITS-1:0]    m_error_address;
    logic [WORD_BITS-1:0]    m_expected_word;
    logic [WORD_BITS-1:0]    m_good_run;
    logic                    m_passed;

    slot_predictor engine_model = new();

    int          gap_odds   = 4;     // 1-in-N chance of an idle burst per word, 0 = none
    bit          hold_req   = 1'b0;  // ask the result side for one long hold-off
    int          words_sent = 0;
    int unsigned cycles     = 0;

    lfsr_memory_pattern_checker_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_read_data     (s_read_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_command       (m_command),
        .m_word_address  (m_word_address),
        .m_write_data    (m_write_data),
        .m_mismatch      (m_mismatch),
        .m_error_address (m_error_address),
        .m_expected_word (m_expected_word),
        .m_good_run      (m_good_run),
        .m_passed        (m_passed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------------

    // Offer one word, optionally after a short idle burst, and hold it until taken.
    // The model is advanced here, in the same process, so the next word can be
    // built from up-to-date state without racing the edge.
    task automatic send_word(logic act, logic [WORD_BITS-1:0] rd);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_read_data <= rd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        engine_model.accept_word(act, rd);
        words_sent++;
    endtask

    // Step the engine as a healthy memory would answer: return the word the
    // last read should see, flipping one bit now and then to plant an error.
    task automatic run_steps(int count, int bad_odds);
        logic [WORD_BITS-1:0] rd;
        repeat (count) begin
            rd = engine_model.pend ? engine_model.pend_word : $urandom();
            if (bad_odds != 0 && $urandom_range(1, bad_odds) == 1)
                rd = rd ^ (32'd1 << $urandom_range(0, WORD_BITS - 1));
            send_word(ACT_STEP, rd);
        end
    endtask

    // Drop valid and wait until every outstanding command word has come back.
    task automatic settle();
        s_valid <= 1'b0;
        while (engine_model.due_cmds.size() != 0) @(posedge aclk);
    endtask

    // Write all four registers, one per edge; call only with the engine idle.
    task automatic program_regs(cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TEST_MODE;
        cfg_wdata <= 32'(c.test_mode);
        @(posedge aclk);
        cfg_index <= REG_SEED_VALUE;
        cfg_wdata <= c.seed;
        @(posedge aclk);
        cfg_index <= REG_SIZE_MB;
        cfg_wdata <= 32'(c.size_mb);
        @(posedge aclk);
        cfg_index <= REG_PASS_COUNT;
        cfg_wdata <= 32'(c.pass_count);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        engine_model.load_cfg(c);
    endtask

    // ---------------------------------------------------------------------
    // Result side: check every accepted word, stall in short bursts, and
    // serve one long hold-off so the engine backs up into its input.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int        stall;
        slot_cmd_t got;
        stall = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready) begin
                got.command   = cmd_t'(m_command);
                got.addr      = m_word_address;
                got.wdata     = m_write_data;
                got.mismatch  = m_mismatch;
                got.err_addr  = m_error_address;
                got.want_word = m_expected_word;
                got.run       = m_good_run;
                got.passed    = m_passed;
                engine_model.check_command(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                    stall = $urandom_range(1, 3);
            end
        end
    end

    // Hang guard.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d command words still due",
                 cycles, engine_model.due_cmds.size());
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        cfg_t cfg;
        logic act;
        int   tests;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: steps before any start must yield no command.
        send_word(ACT_STEP, 32'h0000_0000);
        send_word(ACT_STEP, 32'hffff_ffff);

        // Start on reset defaults, a few linear writes, then restart mid-test.
        send_word(ACT_START, 32'hffff_ffff);
        send_word(ACT_STEP, 32'h0000_0000);
        send_word(ACT_STEP, 32'hffff_ffff);
        send_word(ACT_STEP, $urandom());
        send_word(ACT_START, 32'h0000_0000);
        send_word(ACT_STEP, $urandom());
        settle();

        // Zero size: finish at once with a pass, and repeat the finish report.
        program_regs('{test_mode: 1'b0, seed: 32'hffff_ffff, size_mb: 10'd0,
                       pass_count: 7'h7f});
        send_word(ACT_START, $urandom());
        send_word(ACT_STEP, $urandom());
        send_word(ACT_STEP, $urandom());
        send_word(ACT_STEP, $urandom());
        settle();

        // Random mode with an all-zero seed (the register stays stuck) and
        // the largest size; zero pass count.
        program_regs('{test_mode: 1'b1, seed: 32'h0, size_mb: 10'h3ff, pass_count: 7'd0});
        send_word(ACT_START, $urandom());
        run_steps(3, 0);
        settle();

        // Random mode with an all-ones seed, one pass; abort and restart.
        program_regs('{test_mode: 1'b1, seed: 32'hffff_ffff, size_mb: 10'd1,
                       pass_count: 7'd1});
        send_word(ACT_START, $urandom());
        run_steps(3, 0);
        send_word(ACT_START, $urandom());
        run_steps(2, 0);

        // Short random tests: random settings, random read data, stray starts,
        // and now and then a size cut to zero in the middle of a test. The
        // last few run with no idling on either side.
        for (tests = 0; tests < SHORT_TESTS; tests++) begin
            settle();
            if (tests >= SHORT_TESTS - QUIET_TESTS) gap_odds = 0;
            cfg.test_mode = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       cfg.seed = '0;
                1:       cfg.seed = '1;
                default: cfg.seed = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0:       cfg.size_mb = '0;
                1:       cfg.size_mb = '1;
                default: cfg.size_mb = SIZE_BITS'($urandom_range(1, 1023));
            endcase
            case ($urandom_range(0, 3))
                0:       cfg.pass_count = '0;
                1:       cfg.pass_count = '1;
                default: cfg.pass_count = PASS_BITS'($urandom_range(0, 127));
            endcase
            program_regs(cfg);
            // hold off the result side while the input keeps offering words
            if (tests == 2) hold_req = 1'b1;
            send_word(ACT_START, $urandom());
            for (int n = 0; n < 24; n++) begin
                if (n == 12 && cfg.size_mb != '0 && $urandom_range(0, 1) == 1) begin
                    settle();
                    cfg.size_mb = '0;
                    program_regs(cfg);
                end
                act = ($urandom_range(0, 15) == 0) ? ACT_START : ACT_STEP;
                send_word(act, $urandom());
            end
        end

        // Drain, then leave room for any stray word to surface.
        settle();
        repeat (16) @(posedge aclk);

        $display("Sent %0d input words: directed cases and %0d short tests in both modes,",
                 words_sent, SHORT_TESTS);
        $display("with stray starts and size cuts; %0d results, %0d read errors, %0d done",
                 engine_model.checked, engine_model.flagged, engine_model.finished);
        if (engine_model.errors == 0 && engine_model.due_cmds.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
